### sv/gsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the generational slot allocator.
// No dependencies; used by generational_slot_allocator_unit.

package gsa_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int REQ_W          = 3;
    localparam int STAT_W         = 2;
    localparam int TEAM_W         = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC      = 3'd0,
        REQ_FREE       = 3'd1,
        REQ_CHECK      = 3'd2,
        REQ_AT_INDEX   = 3'd3,
        REQ_TEAM_COUNT = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ALLOC,
        ST_ALLOC_GEN,
        ST_COUNT,
        ST_DONE
    } state_t;

endpackage

### sv/generational_slot_allocator_unit.sv
`timescale 1ns / 1ps
// Generational slot allocator: slot table, LIFO free stack and request sequencer.
// Depends on gsa_pkg for request codes, status codes and state encoding.

// The block takes one request at a time and answers each with exactly one
// result transfer. Free, liveness check, handle-at-index and unknown requests
// pass through the EXEC and DONE states before the next possible input transfer;
// allocate passes through ALLOC and DONE for a never-used slot or when full,
// and through ALLOC, ALLOC_GEN and DONE when it reuses a slot from the free
// stack, because the popped index must then address the generation memory. A
// team count walks every slot used so far through the team memory's single
// registered read port, one slot a cycle. A finished result sits in the output
// register, so the next request is taken while that result still waits. A
// slot's generation is written as zero when the slot is first handed out, so
// no clearing pass is needed after reset.

module generational_slot_allocator_unit #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [gsa_pkg::REQ_W-1:0]            s_req_type,
    input  logic [$clog2(SLOT_COUNT)-1:0]        s_slot_index,
    input  logic [GEN_BITS-1:0]                  s_handle_generation,
    input  logic [gsa_pkg::TEAM_W-1:0]           s_team_id,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gsa_pkg::STAT_W-1:0]           m_status,
    output logic [$clog2(SLOT_COUNT)-1:0]        m_out_index,
    output logic [GEN_BITS-1:0]                  m_out_generation,
    output logic                                 m_is_alive,
    output logic [$clog2(SLOT_COUNT+1)-1:0]      m_match_count
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int TEAM_W = gsa_pkg::TEAM_W;

    // Memories: generation per slot, team per slot, and the free stack.
    logic [GEN_BITS-1:0] gen_mem   [SLOT_COUNT];
    logic [TEAM_W-1:0]   team_mem  [SLOT_COUNT];
    logic [IDX_W-1:0]    stack_mem [SLOT_COUNT];

    logic [GEN_BITS-1:0] gen_rdata_reg;
    logic [TEAM_W-1:0]   team_rdata_reg;
    logic [IDX_W-1:0]    stack_rdata_reg;

    logic                gen_we;
    logic [IDX_W-1:0]    gen_waddr;
    logic [GEN_BITS-1:0] gen_wdata;
    logic [IDX_W-1:0]    gen_raddr;
    logic                team_we;
    logic [IDX_W-1:0]    team_waddr;
    logic [IDX_W-1:0]    team_raddr;
    logic                stack_we;
    logic [IDX_W-1:0]    stack_waddr;
    logic [IDX_W-1:0]    stack_raddr;
    logic [CNT_W-1:0]    depth_m1;

    // Control state.
    gsa_pkg::state_t     state_reg, state_next;
    logic [SLOT_COUNT-1:0] live_reg, live_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    ever_used_reg, ever_used_next;
    logic [CNT_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic                acc_vld_reg, acc_vld_next;
    logic                m_valid_reg, m_valid_next;

    // Request and result payload.
    logic [gsa_pkg::REQ_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [GEN_BITS-1:0] gen_in_reg, gen_in_next;
    logic [TEAM_W-1:0]   team_reg, team_next;
    logic                live_rd_reg, live_rd_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    gsa_pkg::status_t    res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    logic [GEN_BITS-1:0] res_gen_reg, res_gen_next;
    logic                res_alive_reg, res_alive_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;

    gsa_pkg::status_t    m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;
    logic [GEN_BITS-1:0] m_gen_reg, m_gen_next;
    logic                m_alive_reg, m_alive_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;

    // Handle evaluation for the request held in idx_reg / gen_in_reg.
    logic                in_use;
    logic [GEN_BITS-1:0] gen_eff;
    logic                handle_ok;
    logic                free_ok;
    logic [GEN_BITS-1:0] gen_incr;
    logic                scan_more;

    // A slot at or beyond the used count was never freed, so its generation is zero.
    assign in_use    = CNT_W'(idx_reg) < ever_used_reg;
    assign gen_eff   = in_use ? gen_rdata_reg : '0;
    assign handle_ok = in_use && live_reg[idx_reg] && (gen_eff == gen_in_reg);
    assign free_ok   = handle_ok && (depth_reg < CNT_W'(SLOT_COUNT));
    assign gen_incr  = gen_eff + 1'b1;
    assign scan_more = scan_ptr_reg < ever_used_reg;

    assign depth_m1    = depth_reg - 1'b1;
    assign stack_raddr = depth_m1[IDX_W-1:0];
    assign team_raddr  = scan_ptr_reg[IDX_W-1:0];
    assign gen_raddr   = (state_reg == gsa_pkg::ST_ALLOC) ? stack_rdata_reg : s_slot_index;

    assign s_ready          = (state_reg == gsa_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_out_index      = m_index_reg;
    assign m_out_generation = m_gen_reg;
    assign m_is_alive       = m_alive_reg;
    assign m_match_count    = m_count_reg;

    always_comb begin
        state_next      = state_reg;
        live_next       = live_reg;
        depth_next      = depth_reg;
        ever_used_next  = ever_used_reg;
        scan_ptr_next   = scan_ptr_reg;
        acc_vld_next    = acc_vld_reg;
        m_valid_next    = m_valid_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        gen_in_next     = gen_in_reg;
        team_next       = team_reg;
        live_rd_next    = 1'b0;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        res_alive_next  = res_alive_reg;
        res_count_next  = res_count_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_gen_next      = m_gen_reg;
        m_alive_next    = m_alive_reg;
        m_count_next    = m_count_reg;
        gen_we          = 1'b0;
        gen_waddr       = idx_reg;
        gen_wdata       = gen_incr;
        team_we         = 1'b0;
        team_waddr      = stack_rdata_reg;
        stack_we        = 1'b0;
        stack_waddr     = depth_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            gsa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    idx_next      = s_slot_index;
                    gen_in_next   = s_handle_generation;
                    team_next     = s_team_id;
                    scan_ptr_next = '0;
                    acc_vld_next  = 1'b0;
                    count_next    = '0;
                    case (s_req_type)
                        gsa_pkg::REQ_ALLOC:      state_next = gsa_pkg::ST_ALLOC;
                        gsa_pkg::REQ_TEAM_COUNT: state_next = gsa_pkg::ST_COUNT;
                        default:                 state_next = gsa_pkg::ST_EXEC;
                    endcase
                end
            end

            gsa_pkg::ST_ALLOC: begin
                res_count_next = '0;
                if (depth_reg != '0) begin
                    // Reuse the most recently freed slot; its generation is read next.
                    depth_next                 = depth_m1;
                    idx_next                   = stack_rdata_reg;
                    team_we                    = 1'b1;
                    team_waddr                 = stack_rdata_reg;
                    live_next[stack_rdata_reg] = 1'b1;
                    state_next                 = gsa_pkg::ST_ALLOC_GEN;
                end else if (ever_used_reg < CNT_W'(SLOT_COUNT)) begin
                    // A fresh slot starts at generation zero.
                    gen_we                               = 1'b1;
                    gen_waddr                            = ever_used_reg[IDX_W-1:0];
                    gen_wdata                            = '0;
                    team_we                              = 1'b1;
                    team_waddr                           = ever_used_reg[IDX_W-1:0];
                    live_next[ever_used_reg[IDX_W-1:0]]  = 1'b1;
                    ever_used_next                       = ever_used_reg + 1'b1;
                    res_status_next                      = gsa_pkg::STAT_OK;
                    res_index_next                       = ever_used_reg[IDX_W-1:0];
                    res_gen_next                         = '0;
                    res_alive_next                       = 1'b1;
                    state_next                           = gsa_pkg::ST_DONE;
                end else begin
                    res_status_next = gsa_pkg::STAT_FULL;
                    res_index_next  = '0;
                    res_gen_next    = '0;
                    res_alive_next  = 1'b0;
                    state_next      = gsa_pkg::ST_DONE;
                end
            end

            gsa_pkg::ST_ALLOC_GEN: begin
                res_status_next = gsa_pkg::STAT_OK;
                res_index_next  = idx_reg;
                res_gen_next    = gen_rdata_reg;
                res_alive_next  = 1'b1;
                res_count_next  = '0;
                state_next      = gsa_pkg::ST_DONE;
            end

            gsa_pkg::ST_EXEC: begin
                res_count_next = '0;
                res_alive_next = 1'b0;
                res_gen_next   = '0;
                res_index_next = '0;
                case (req_reg)
                    gsa_pkg::REQ_FREE: begin
                        res_index_next = idx_reg;
                        if (free_ok) begin
                            live_next[idx_reg] = 1'b0;
                            gen_we             = 1'b1;
                            stack_we           = 1'b1;
                            depth_next         = depth_reg + 1'b1;
                            res_status_next    = gsa_pkg::STAT_OK;
                            res_gen_next       = gen_incr;
                        end else begin
                            res_status_next = gsa_pkg::STAT_STALE;
                        end
                    end
                    gsa_pkg::REQ_CHECK: begin
                        res_index_next  = idx_reg;
                        res_gen_next    = gen_in_reg;
                        res_alive_next  = handle_ok;
                        res_status_next = handle_ok ? gsa_pkg::STAT_OK : gsa_pkg::STAT_STALE;
                    end
                    gsa_pkg::REQ_AT_INDEX: begin
                        if (in_use && live_reg[idx_reg]) begin
                            res_status_next = gsa_pkg::STAT_OK;
                            res_index_next  = idx_reg;
                            res_gen_next    = gen_eff;
                            res_alive_next  = 1'b1;
                        end else begin
                            res_status_next = gsa_pkg::STAT_STALE;
                        end
                    end
                    default: begin
                        res_status_next = gsa_pkg::STAT_STALE;
                    end
                endcase
                state_next = gsa_pkg::ST_DONE;
            end

            gsa_pkg::ST_COUNT: begin
                // One slot is fetched per cycle; the previous fetch is scored.
                if (acc_vld_reg && live_rd_reg && (team_rdata_reg == team_reg)) begin
                    count_next = count_reg + 1'b1;
                end
                if (scan_more) begin
                    live_rd_next  = live_reg[scan_ptr_reg[IDX_W-1:0]];
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                    acc_vld_next  = 1'b1;
                end else begin
                    acc_vld_next = 1'b0;
                    if (!acc_vld_reg) begin
                        res_status_next = gsa_pkg::STAT_OK;
                        res_index_next  = '0;
                        res_gen_next    = '0;
                        res_alive_next  = 1'b0;
                        res_count_next  = count_reg;
                        state_next      = gsa_pkg::ST_DONE;
                    end
                end
            end

            gsa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_gen_next    = res_gen_reg;
                    m_alive_next  = res_alive_reg;
                    m_count_next  = res_count_reg;
                    state_next    = gsa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gsa_pkg::ST_IDLE;
            live_reg      <= '0;
            depth_reg     <= '0;
            ever_used_reg <= '0;
            scan_ptr_reg  <= '0;
            acc_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            depth_reg     <= depth_next;
            ever_used_reg <= ever_used_next;
            scan_ptr_reg  <= scan_ptr_next;
            acc_vld_reg   <= acc_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        gen_in_reg     <= gen_in_next;
        team_reg       <= team_next;
        live_rd_reg    <= live_rd_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        res_alive_reg  <= res_alive_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_gen_reg      <= m_gen_next;
        m_alive_reg    <= m_alive_next;
        m_count_reg    <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (gen_we) begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        gen_rdata_reg <= gen_mem[gen_raddr];
    end

    always_ff @(posedge aclk) begin
        if (team_we) begin
            team_mem[team_waddr] <= team_reg;
        end
        team_rdata_reg <= team_mem[team_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= idx_reg;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    // Every freed slot was once handed out, so the stack never outgrows the used count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= ever_used_reg)
        else $error("free stack deeper than the number of slots ever used");

    // Live slots all lie below the used count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'($countones(live_reg)) <= ever_used_reg)
        else $error("more live slots than slots ever used");

    // The team scan never runs past the used region.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gsa_pkg::ST_COUNT) |-> (scan_ptr_reg <= ever_used_reg))
        else $error("team scan pointer beyond used slots");

    // A successful free pushes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gsa_pkg::ST_EXEC && req_reg == gsa_pkg::REQ_FREE && free_ok)
        |=> (depth_reg == $past(depth_reg) + 1'b1))
        else $error("free did not push onto the free stack");

endmodule
